// ===== hw/rtl/bsk_pkg.sv =====
package bsk_pkg;

    localparam int MAX_LEN = 1024;
    localparam int DEPTH   = MAX_LEN + 1;
    // ones count, bit count and histogram address
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    // one histogram entry can reach MAX_LEN + 1
    localparam int HIST_W  = $clog2(MAX_LEN + 2);
    localparam int TGT_W   = 11;
    localparam int TOTAL_W = 20;
    localparam int CMP_W   = (CNT_W > TGT_W) ? CNT_W : TGT_W;
    localparam int SUM_W   = ((TOTAL_W > HIST_W) ? TOTAL_W : HIST_W) + 1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // request handed from the histogram stage to the accumulator
    typedef struct packed {
        logic              use_mem;    // add the histogram read data
        logic [HIST_W-1:0] add_const;  // otherwise add this
        logic              last;
        logic              ovf;
    } hist_req_t;

endpackage

// ===== hw/rtl/binary_substring_k_ones_counter.sv =====
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata[0] bit_value, tlast end_of_string
// m_axis    out  m_axis_tvalid/tready       tdata[19:0] substring_total,
//                                           tlast final_result, tuser length_overflow
// cfg       in   cfg_valid/cfg_ready        cfg_data target_ones
//
// One bit per cycle sustained unless m_axis stalls; results are registered in bsk_accum.
// The rate is set by the histogram RAM: at most one read and one write per bit, the
// write issued in the accept cycle so no read ever hits an entry in flight.
// No clearing pass: entries are trusted only up to the current ones count.
// Reset is asynchronous and active low; cfg_ready is always high.
// A stall on m_axis holds the result and backs up into s_axis after one request.
module binary_substring_k_ones_counter
    import bsk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] bit_value, [7:1] zero
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [19:0] substring_total, [23:20] zero
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // [0] length_overflow
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data
);

    logic [TGT_W-1:0]   target_reg;
    logic               req_valid;
    logic               req_adv;
    hist_req_t          req;
    logic [HIST_W-1:0]  rd_data;
    logic [TOTAL_W-1:0] out_total;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TGT_W'(1);
        end
        else if (cfg_valid)
        begin
            target_reg <= cfg_data;
        end
    end

    bsk_hist u_hist (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .bit_value     (s_axis_tdata[0]),
        .end_of_string (s_axis_tlast),
        .target_ones   (target_reg),
        .req_adv       (req_adv),
        .req_valid     (req_valid),
        .req           (req),
        .rd_data       (rd_data)
    );

    bsk_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_adv   (req_adv),
        .req       (req),
        .rd_data   (rd_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_total (out_total),
        .out_last  (m_axis_tlast),
        .out_ovf   (m_axis_tuser)
    );

    assign m_axis_tdata = {4'b0000, out_total};

endmodule

// ===== hw/rtl/bsk_hist.sv =====
module bsk_hist
    import bsk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              bit_value,
    input  logic              end_of_string,
    input  logic [TGT_W-1:0]  target_ones,
    input  logic              req_adv,
    output logic              req_valid,
    output hist_req_t         req,
    output logic [HIST_W-1:0] rd_data
);

    logic [HIST_W-1:0] mem [DEPTH];

    logic [CNT_W-1:0]  ones_reg;
    logic [CNT_W-1:0]  bits_seen_reg;
    logic [HIST_W-1:0] cur_reg;        // histogram entry at ones_reg
    logic              zero_written_reg;
    logic              req_valid_reg;
    hist_req_t         req_reg;
    logic [HIST_W-1:0] rd_data_reg;

    logic              accept;
    logic              ovf;
    logic [CNT_W-1:0]  ones_next;
    logic [HIST_W-1:0] cur_next;
    logic [CMP_W-1:0]  ones_ext;
    logic [CMP_W-1:0]  tgt_ext;
    logic [CMP_W-1:0]  diff;
    logic [CNT_W-1:0]  idx;
    logic              hit;
    hist_req_t         req_next;

    assign in_ready = !req_valid_reg || req_adv;
    assign accept   = in_valid && in_ready;

    assign ovf       = bits_seen_reg >= CNT_W'(MAX_LEN);
    assign ones_next = ones_reg + CNT_W'(bit_value);
    // a fresh ones count lands on an entry not yet touched in this string
    assign cur_next  = bit_value ? HIST_W'(1) : cur_reg + HIST_W'(1);
    assign ones_ext  = CMP_W'(ones_next);
    assign tgt_ext   = CMP_W'(target_ones);
    assign hit       = ones_ext >= tgt_ext;
    assign diff      = ones_ext - tgt_ext;
    assign idx       = diff[CNT_W-1:0];

    always_comb
    begin
        req_next.use_mem   = 1'b0;
        req_next.add_const = '0;
        req_next.last      = end_of_string;
        req_next.ovf       = ovf;
        if (!ovf && hit)
        begin
            if (target_ones == '0)
            begin
                // read before increment: entry at the new count
                req_next.add_const = bit_value ? '0 : cur_reg;
            end
            else if (idx == '0 && !zero_written_reg)
            begin
                req_next.add_const = HIST_W'(1);
            end
            else
            begin
                req_next.use_mem = 1'b1;
            end
        end
    end

    // write in the accept cycle, so later reads never need forwarding
    always_ff @(posedge clk)
    begin
        if (accept && !ovf)
        begin
            mem[ones_next] <= cur_next;
        end
        if (accept && req_next.use_mem)
        begin
            rd_data_reg <= mem[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ones_reg         <= '0;
            bits_seen_reg    <= '0;
            cur_reg          <= HIST_W'(1);
            zero_written_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (end_of_string)
            begin
                ones_reg         <= '0;
                bits_seen_reg    <= '0;
                cur_reg          <= HIST_W'(1);
                zero_written_reg <= 1'b0;
            end
            else if (!ovf)
            begin
                ones_reg         <= ones_next;
                bits_seen_reg    <= bits_seen_reg + CNT_W'(1);
                cur_reg          <= cur_next;
                zero_written_reg <= zero_written_reg || (ones_next == '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            req_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_next;
        end
    end

    assign req_valid = req_valid_reg;
    assign req       = req_reg;
    assign rd_data   = rd_data_reg;

    a_read_written: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req_next.use_mem |->
            ((idx != '0) ? (idx <= ones_reg) : zero_written_reg))
        else $error("histogram read of an entry not written in this string");

    a_cur_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg != '0)
        else $error("current histogram entry is zero");

    a_ovf_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ovf && !end_of_string |=>
            ones_reg == $past(ones_reg) && cur_reg == $past(cur_reg))
        else $error("ignored bit changed string state");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_string |=>
            ones_reg == '0 && bits_seen_reg == '0 && !zero_written_reg)
        else $error("string state not cleared after last bit");

endmodule

// ===== hw/rtl/bsk_accum.sv =====
module bsk_accum
    import bsk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_adv,
    input  hist_req_t          req,
    input  logic [HIST_W-1:0]  rd_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [TOTAL_W-1:0] out_total,
    output logic               out_last,
    output logic               out_ovf
);

    logic [TOTAL_W-1:0] total_reg;
    logic               out_valid_reg;
    logic [TOTAL_W-1:0] out_total_reg;
    logic               out_last_reg;
    logic               out_ovf_reg;

    logic               take;
    logic [HIST_W-1:0]  add;
    logic [SUM_W-1:0]   sum;
    logic [TOTAL_W-1:0] sat;

    assign req_adv = !out_valid_reg || out_ready;
    assign take    = req_valid && req_adv;
    assign add     = req.use_mem ? rd_data : req.add_const;
    assign sum     = SUM_W'(total_reg) + SUM_W'(add);
    assign sat     = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (req_adv)
        begin
            out_valid_reg <= req_valid;
            if (req_valid)
            begin
                total_reg <= req.last ? '0 : sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_total_reg <= sat;
            out_last_reg  <= req.last;
            out_ovf_reg   <= req.ovf;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_total = out_total_reg;
    assign out_last  = out_last_reg;
    assign out_ovf   = out_ovf_reg;

    a_total_grows: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_total_reg >= $past(total_reg))
        else $error("running total went down");

    a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
        take && req.last |=> total_reg == '0)
        else $error("running total not cleared after last bit");

    a_ovf_repeats: assert property (@(posedge clk) disable iff (!rst_n)
        take && req.ovf |=> out_total_reg == $past(total_reg))
        else $error("ignored bit changed the total");

endmodule
